// ----- rtl/strdec_pkg.sv -----
// Shared types, character constants and encoding functions for the string escape decoder.
package strdec_pkg;

  typedef enum logic [2:0] {
    PH_PLAIN,
    PH_BACKSLASH,
    PH_OCTAL,
    PH_HEX,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TRUNCATED,
    ST_BAD_HEX,
    ST_BAD_CODE_POINT,
    ST_NAMED_UNSUPPORTED
  } status_e;

  // Configuration register indexes.
  localparam logic CfgRawMode     = 1'b0;
  localparam logic CfgUnicodeMode = 1'b1;

  // Characters the decoder recognises.
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChUpperU    = 8'h55;
  localparam logic [7:0] ChUpperN    = 8'h4e;
  localparam logic [7:0] ChDigit0    = 8'h30;
  localparam logic [7:0] ChDigit7    = 8'h37;

  // Decoder state carried from one transfer to the next.
  typedef struct packed {
    phase_e      phase;
    logic [31:0] value;
    logic [3:0]  taken;
    logic [3:0]  wanted;
    logic        bad;
    status_e     err;
    logic        any;
  } dec_state_t;

  // Everything one input transfer produces: up to four bytes plus end information.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      num;
    logic            fin;
    status_e         status;
    logic            esc;
  } bundle_t;

  typedef struct packed {
    logic            ok;
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // UTF-8 encoding of a code point; ok is low for surrogates and values beyond the range.
  function automatic utf8_t utf8_encode(input logic [31:0] cp);
    utf8_t r;
    r    = '0;
    r.ok = 1'b1;
    if (cp >= 32'h0000_d800 && cp <= 32'h0000_dfff) begin
      r.ok = 1'b0;
    end else if (cp <= 32'h0000_007f) begin
      r.len      = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 32'h0000_07ff) begin
      r.len      = 3'd2;
      r.bytes[0] = 8'hc0 | {3'b000, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp <= 32'h0000_ffff) begin
      r.len      = 3'd3;
      r.bytes[0] = 8'he0 | {4'b0000, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp <= 32'h0010_ffff) begin
      r.len      = 3'd4;
      r.bytes[0] = 8'hf0 | {5'b00000, cp[20:18]};
      r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Bit 4 is set for a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Bit 8 is set when the byte names a single-character escape, bits 7:0 give its value.
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0b};
      8'h5c,
      8'h27,
      8'h22:   r = {1'b1, b};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/strdec_decode.sv -----
// Single-pass escape decode of one text byte into a bundle of output bytes and the next state.
module strdec_decode import strdec_pkg::*; (
  input  dec_state_t state_i,
  input  logic [7:0] byte_i,
  input  logic       fin_i,
  input  logic       raw_i,
  input  logic       uni_i,
  output dec_state_t state_o,
  output bundle_t    bundle_o,
  output logic       push_o
);

  dec_state_t      nx;
  logic            num_go;
  logic            num_hex;
  logic [31:0]     num_val;
  utf8_t           enc;
  logic [3:0][7:0] lit;
  logic [2:0]      lit_len;
  logic            tail_vld;
  logic [3:0][7:0] pb;
  logic [2:0]      plen;
  logic [3:0][7:0] out_bytes;
  logic [2:0]      total;
  logic            is_oct;
  logic [2:0]      oct_d;
  logic [4:0]      hx;
  logic [8:0]      sv;
  logic            wide;
  logic [3:0]      taken_inc;
  logic [31:0]     oct_val;
  logic [31:0]     hex_val;

  assign is_oct    = (byte_i >= ChDigit0) && (byte_i <= ChDigit7);
  assign oct_d     = byte_i[2:0];
  assign hx        = hex_value(byte_i);
  assign sv        = simple_escape(byte_i);
  assign wide      = uni_i && ((byte_i == ChLowerU) || (byte_i == ChUpperU));
  assign taken_inc = state_i.taken + 4'd1;
  assign oct_val   = {state_i.value[28:0], oct_d};
  assign hex_val   = {state_i.value[27:0], hx[3:0]};

  always_comb begin
    nx       = state_i;
    num_go   = 1'b0;
    num_hex  = 1'b0;
    num_val  = state_i.value;
    lit      = '0;
    lit_len  = 3'd0;
    tail_vld = 1'b0;

    unique case (state_i.phase)
      PH_PLAIN: begin
        // A backslash on the final byte has nothing to escape and goes out as it is.
        if (byte_i != ChBackslash || fin_i) begin
          lit[0]  = byte_i;
          lit_len = 3'd1;
        end else begin
          nx.phase = PH_BACKSLASH;
        end
      end
      PH_BACKSLASH: begin
        nx.phase = PH_PLAIN;
        if (byte_i == ChNewline) begin
          // Line continuation produces nothing.
        end else if (raw_i && !wide) begin
          lit[0]  = ChBackslash;
          lit[1]  = byte_i;
          lit_len = 3'd2;
        end else begin
          nx.any = 1'b1;
          if (sv[8]) begin
            lit[0]  = sv[7:0];
            lit_len = 3'd1;
          end else if (is_oct) begin
            nx.value = {29'd0, oct_d};
            nx.taken = 4'd1;
            nx.phase = PH_OCTAL;
          end else if (byte_i == ChLowerX || wide) begin
            nx.wanted = (byte_i == ChLowerX) ? 4'd2 : ((byte_i == ChLowerU) ? 4'd4 : 4'd8);
            nx.taken  = 4'd0;
            nx.value  = '0;
            nx.bad    = 1'b0;
            nx.phase  = PH_HEX;
          end else if (uni_i && byte_i == ChUpperN) begin
            nx.err   = ST_NAMED_UNSUPPORTED;
            nx.phase = PH_ERROR;
          end else begin
            lit[0]  = ChBackslash;
            lit[1]  = byte_i;
            lit_len = 3'd2;
          end
        end
      end
      PH_OCTAL: begin
        if (is_oct) begin
          nx.value = oct_val;
          nx.taken = taken_inc;
          if (taken_inc >= 4'd3) begin
            num_go   = 1'b1;
            num_val  = oct_val;
            nx.phase = PH_PLAIN;
          end
        end else begin
          // The octal value goes out first, then the byte is handled as plain text.
          num_go   = 1'b1;
          num_val  = state_i.value;
          nx.phase = PH_PLAIN;
          if (byte_i != ChBackslash || fin_i) begin
            tail_vld = 1'b1;
          end else begin
            nx.phase = PH_BACKSLASH;
          end
        end
      end
      PH_HEX: begin
        if (hx[4]) begin
          nx.value = hex_val;
        end else begin
          nx.bad = 1'b1;
        end
        nx.taken = taken_inc;
        if (taken_inc >= state_i.wanted) begin
          nx.phase = PH_PLAIN;
          if (nx.bad) begin
            nx.err   = ST_BAD_HEX;
            nx.phase = PH_ERROR;
          end else begin
            num_go  = 1'b1;
            num_hex = 1'b1;
            num_val = nx.value;
          end
        end
      end
      PH_ERROR: begin
        // Bytes are dropped until the end of the literal.
      end
      default: begin
        nx.phase = PH_ERROR;
      end
    endcase

    // End of the literal while an escape is still open.
    if (fin_i) begin
      if (nx.phase == PH_OCTAL) begin
        num_go   = 1'b1;
        num_val  = nx.value;
        nx.phase = PH_PLAIN;
      end else if (nx.phase == PH_HEX) begin
        nx.err   = ST_TRUNCATED;
        nx.phase = PH_ERROR;
      end
    end

    enc  = utf8_encode(num_val);
    pb   = lit;
    plen = lit_len;
    if (num_go) begin
      if (uni_i) begin
        if (enc.ok) begin
          pb   = enc.bytes;
          plen = enc.len;
        end else if (num_hex) begin
          nx.err   = ST_BAD_CODE_POINT;
          nx.phase = PH_ERROR;
        end
      end else begin
        pb   = {24'd0, num_val[7:0]};
        plen = 3'd1;
      end
    end

    for (int i = 0; i < 4; i++) begin
      if (3'(i) < plen) begin
        out_bytes[i] = pb[i];
      end else if (3'(i) == plen && tail_vld) begin
        out_bytes[i] = byte_i;
      end else begin
        out_bytes[i] = 8'd0;
      end
    end
    total = plen + {2'b00, tail_vld};

    bundle_o.bytes  = out_bytes;
    bundle_o.num    = total;
    bundle_o.fin    = fin_i;
    bundle_o.status = nx.err;
    bundle_o.esc    = nx.any;
    push_o          = fin_i || (total != 3'd0);

    // Each literal starts from a clean state.
    if (fin_i) begin
      nx.phase  = PH_PLAIN;
      nx.value  = '0;
      nx.taken  = '0;
      nx.wanted = '0;
      nx.bad    = 1'b0;
      nx.err    = ST_OK;
      nx.any    = 1'b0;
    end
    state_o = nx;
  end

endmodule

// ----- rtl/string_escape_decoder.sv -----
// Top level of the string escape decoder: state, configuration and output queue.
//
// Usage: the content bytes of one quoted string literal arrive on the slave stream, one byte
// per transfer, with s_axis_tlast_i marking the last byte of the literal. Each byte is decoded
// in the cycle it is accepted and yields zero to four output bytes, which leave on the master
// stream one byte per transfer. m_axis_tlast_o marks the final output of the literal, and on
// that transfer tuser carries the literal's status and whether any escape was decoded. A
// literal whose last byte produces nothing still ends with a bare end marker (byte_present
// low, data zero).
// Outputs are read from the registered result queue, never directly from the decoder.
// Throughput: one input byte per cycle while each byte yields at most one output and the
// receiver is ready; a byte that yields several outputs keeps its queue entry until all have
// left, since the output side moves one byte per cycle. A two-entry result queue sits between
// the sides, so a new input is taken while a finished result is still waiting.
// Reset clears the decoder state, the modes and the queue. When the receiver stalls, the queue
// fills and s_axis_tready_o drops; nothing is lost. The user writes the raw and unicode modes
// through the configuration port only while the block is idle; the block does not enforce it.
module string_escape_decoder import strdec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_data_i,
  // Input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tlast_i,   // final_byte
  // Output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] decoded_byte
  output logic [5:0] m_axis_tuser_o,   // [0] byte_present, [1] run_last, [4:2] status,
                                       // [5] escape_seen
  output logic       m_axis_tlast_o    // literal_end
);

  dec_state_t state_q;
  dec_state_t state_d;
  logic       raw_q;
  logic       uni_q;
  bundle_t    bundle_d;
  logic       push;

  // Two-entry queue of result bundles.
  bundle_t    queue_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] idx_q;

  bundle_t    head;
  logic [1:0] last_idx;
  logic       run_last;
  logic       in_fire;
  logic       out_fire;
  logic       do_push;
  logic       do_pop;

  strdec_decode u_decode (
    .state_i  (state_q),
    .byte_i   (s_axis_tdata_i),
    .fin_i    (s_axis_tlast_i),
    .raw_i    (raw_q),
    .uni_i    (uni_q),
    .state_o  (state_d),
    .bundle_o (bundle_d),
    .push_o   (push)
  );

  assign s_axis_tready_o = (count_q != 2'd2);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign do_push         = in_fire && push;

  assign head     = queue_q[rd_ptr_q];
  assign last_idx = (head.num == 3'd0) ? 2'd0 : 2'(head.num - 3'd1);
  assign run_last = (idx_q == last_idx);

  assign m_axis_tvalid_o = (count_q != 2'd0);
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;
  assign do_pop          = out_fire && run_last;

  assign m_axis_tdata_o    = head.bytes[idx_q];
  assign m_axis_tlast_o    = head.fin && run_last;
  assign m_axis_tuser_o[0] = (head.num != 3'd0);
  assign m_axis_tuser_o[1] = run_last;
  assign m_axis_tuser_o[4:2] = m_axis_tlast_o ? head.status : ST_OK;
  assign m_axis_tuser_o[5] = m_axis_tlast_o && head.esc;

  // Mode registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= 1'b0;
      uni_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRawMode:     raw_q <= cfg_data_i;
        CfgUnicodeMode: uni_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Decoder state advances on every accepted input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= bundle_d;
    end
  end

  // Queue pointers and the byte index within the head bundle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        idx_q    <= 2'd0;
      end else if (out_fire) begin
        idx_q <= idx_q + 2'd1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/strdec_checker.sv -----
// Port-level assertions for the string escape decoder, bound to the top level.
module strdec_checker import strdec_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i,
  input logic [5:0] m_axis_tuser_i,
  input logic       m_axis_tlast_i
);

  // A stalled output transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i)
      && $stable(m_axis_tlast_i))
    else $error("output payload changed while stalled");

  // The end of a literal is always the last output of its input byte.
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tlast_i |-> m_axis_tuser_i[1])
    else $error("literal end without run_last");

  // Status and escape flag are only reported on the end marker.
  a_status_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tlast_i |->
      m_axis_tuser_i[4:2] == ST_OK && !m_axis_tuser_i[5])
    else $error("status reported before literal end");

  // A transfer without a byte is a bare end marker with zero data.
  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tuser_i[0] |->
      m_axis_tlast_i && m_axis_tdata_i == 8'd0)
    else $error("malformed bare end marker");

endmodule

bind string_escape_decoder strdec_checker u_strdec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
